// File: rtl/core/cllc_pkg.sv
// ============================================================================
// cllc_pkg: canal lock controller shared types
// Encodings for events, door states, commands, modes, and the packed
// request/result/state records used by the top level and the step logic.
// ============================================================================
package cllc_pkg;

    typedef enum logic [3:0] {
        EV_NONE          = 4'd0,
        EV_ALARM         = 4'd1,
        EV_EMERG_BUTTON  = 4'd2,
        EV_RESUME        = 4'd3,
        EV_START         = 4'd4,
        EV_DOOR_CHANGED  = 4'd5,
        EV_REL_OUTSIDE   = 4'd6,
        EV_REL_INSIDE    = 4'd7,
        EV_LEVEL_CHANGED = 4'd8
    } event_t;

    // door states as reported by the door controllers
    localparam logic [2:0] DOOR_LOCKED  = 3'd0;
    localparam logic [2:0] DOOR_CLOSED  = 3'd1;
    localparam logic [2:0] DOOR_OPEN    = 3'd2;
    localparam logic [2:0] DOOR_CLOSING = 3'd3;
    localparam logic [2:0] DOOR_OPENING = 3'd4;
    localparam logic [2:0] DOOR_STOPPED = 3'd5;
    localparam logic [2:0] DOOR_DAMAGE  = 3'd6;

    // water levels; anything above HIGH reads as HIGH
    localparam logic [2:0] LVL_LOW       = 3'd0;
    localparam logic [2:0] LVL_BELOW_MID = 3'd1;
    localparam logic [2:0] LVL_ABOVE_MID = 3'd2;
    localparam logic [2:0] LVL_ABOVE_UP  = 3'd3;
    localparam logic [2:0] LVL_HIGH      = 3'd4;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2,
        CMD_STOP  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_EMERGENCY = 3'd0,
        MODE_OPENING   = 3'd1,
        MODE_CLOSING   = 3'd2,
        MODE_OPEN      = 3'd3,
        MODE_OUT_GREEN = 3'd4,
        MODE_IN_GREEN  = 3'd5,
        MODE_RAISING   = 3'd6,
        MODE_LOWERING  = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_LOW  = 2'd1,
        SEL_HIGH = 2'd2
    } sel_t;

    typedef enum logic [1:0] {
        FLT_NONE      = 2'd0,
        FLT_DAMAGE    = 2'd1,
        FLT_BOTH_OPEN = 2'd2
    } fault_t;

    // valve masks: low door bits 2:0, high door bits 5:3
    localparam logic [5:0] VALVE_LOW_LOWER = 6'h01;
    localparam logic [5:0] VALVE_LOW_ALL   = 6'h07;
    localparam logic [5:0] VALVE_HIGH_ALL  = 6'h38;
    localparam logic [5:0] VALVE_HIGH_1    = 6'h08;
    localparam logic [5:0] VALVE_HIGH_2    = 6'h18;

    // one event request, last field in the low bits
    typedef struct packed {
        logic [2:0] water_level;
        logic [2:0] high_door_state;
        logic [2:0] low_door_state;
        logic [3:0] event_code;
    } req_t;

    localparam int unsigned REQ_W  = $bits(req_t);
    localparam int unsigned REQ_TW = ((REQ_W + 7) / 8) * 8;

    // one result, last field in the low bits
    typedef struct packed {
        fault_t     fault;
        sel_t       door_in_use;
        mode_t      mode_now;
        cmd_t       high_door_command;
        cmd_t       low_door_command;
        logic [3:0] lights_green;
        logic [5:0] valves_open;
    } res_t;

    localparam int unsigned RES_W  = $bits(res_t);
    localparam int unsigned RES_TW = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic       started;
        mode_t      mode;
        sel_t       sel;
        logic [5:0] valve;
        logic [3:0] green;
    } state_t;

endpackage

// File: rtl/core/canal_lock_controller.sv
// ============================================================================
// canal_lock_controller: lock sequencing for a two-door canal lock
// Event-driven controller that drives valves, traffic lights and door motors.
// ============================================================================
// One event request is taken per clock while s_tready is high. It lands in an
// input register, the step logic evaluates it against the controller state in
// a single pass, and the result is loaded into the output register, which
// drives m_tvalid, in the same edge that updates the state. A new request can
// follow every cycle unless s_tready drops. The state update loop runs state
// register -> step logic -> state register. Both sides are decoupled by the
// input and output registers; s_tready drops only while the input register
// holds a request and the output register holds an untaken result. The first
// request after reset runs start-up (its event is ignored); a failed start-up
// is retried on the next request. Fault results leave the state unchanged and
// carry no door commands.
// ============================================================================
module canal_lock_controller (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata, from bit 0: event_code[3:0], low_door_state[2:0],
    // high_door_state[2:0], water_level[2:0], zero fill
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cllc_pkg::REQ_TW-1:0]        s_tdata,
    // m_tdata, from bit 0: valves_open[5:0], lights_green[3:0],
    // low_door_command[1:0], high_door_command[1:0], mode_now[2:0],
    // door_in_use[1:0], fault[1:0], zero fill
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cllc_pkg::RES_TW-1:0]        m_tdata
);

    // input register
    logic               in_valid_reg, in_valid_next;
    cllc_pkg::req_t     in_req_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    cllc_pkg::res_t     out_res_reg;

    // controller state
    cllc_pkg::state_t   state_reg, state_next;
    cllc_pkg::res_t     step_res;

    logic               advance;   // input register moves into output register
    logic               take_in;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) out_valid_next = 1'b0;
        if (advance) begin
            out_valid_next = 1'b1;
            in_valid_next  = 1'b0;
        end
        if (take_in) in_valid_next = 1'b1;
    end

    cllc_step u_step (
        .st      (state_reg),
        .req     (in_req_reg),
        .st_next (state_next),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (take_in) in_req_reg <= s_tdata[cllc_pkg::REQ_W-1:0];
        if (advance) out_res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(cllc_pkg::RES_TW - cllc_pkg::RES_W){1'b0}}, out_res_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // state only moves when a request is evaluated
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("state changed without a request");

    // faulted results never carry door commands
    a_fault_no_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.fault != cllc_pkg::FLT_NONE) |->
        (out_res_reg.low_door_command == cllc_pkg::CMD_NONE &&
         out_res_reg.high_door_command == cllc_pkg::CMD_NONE))
        else $error("door command issued with a fault");

    // emergency keeps every valve shut and every light red
    a_emerg_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == cllc_pkg::MODE_EMERGENCY) |->
        (state_reg.valve == '0 && state_reg.green == '0))
        else $error("valve or light active in emergency");

    // a result is evaluated only when the output register is free or drained
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(out_res_reg) && m_tvalid))
        else $error("pending result overwritten");

endmodule

// File: rtl/core/cllc_step.sv
// ============================================================================
// cllc_step: single-event state update
// Pure combinational next-state and result logic for one event request.
// ============================================================================
module cllc_step (
    input  cllc_pkg::state_t st,
    input  cllc_pkg::req_t   req,
    output cllc_pkg::state_t st_next,
    output cllc_pkg::res_t   res
);

    typedef struct packed {
        cllc_pkg::mode_t mode;
        cllc_pkg::sel_t  sel;
        logic [3:0]      green;
        cllc_pkg::cmd_t  cmd;
        logic            damaged;
    } entry_t;

    // take one door into service
    function automatic entry_t enter_door(cllc_pkg::sel_t sel, logic [2:0] ds,
                                          logic [3:0] green);
        entry_t e;
        e.sel     = sel;
        e.green   = (sel == cllc_pkg::SEL_HIGH) ? (green & 4'b0011) : (green & 4'b1100);
        e.damaged = (ds >= cllc_pkg::DOOR_DAMAGE);
        e.cmd     = cllc_pkg::CMD_NONE;
        e.mode    = cllc_pkg::MODE_OPENING;
        if (ds == cllc_pkg::DOOR_OPEN) begin
            e.mode = cllc_pkg::MODE_OPEN;
        end else if (ds == cllc_pkg::DOOR_CLOSING) begin
            e.mode = cllc_pkg::MODE_CLOSING;
            e.cmd  = cllc_pkg::CMD_CLOSE;
        end else begin
            e.cmd  = cllc_pkg::CMD_OPEN;
        end
        return e;
    endfunction

    function automatic logic [5:0] raise_water(logic [2:0] lvl, logic [5:0] v);
        logic [5:0] r;
        r = v;
        case (lvl)
            cllc_pkg::LVL_LOW, cllc_pkg::LVL_BELOW_MID: r = v | cllc_pkg::VALVE_HIGH_1;
            cllc_pkg::LVL_ABOVE_MID: r = v | cllc_pkg::VALVE_HIGH_2;
            cllc_pkg::LVL_ABOVE_UP:  r = v | cllc_pkg::VALVE_HIGH_ALL;
            default:                 r = v;
        endcase
        return r;
    endfunction

    logic [3:0]        ev;
    logic [2:0]        lo, hi, lvl, sel_ds;
    logic [1:0]        gs;
    logic [3:0]        ins, outs;
    logic              lo_open, hi_open;
    entry_t            ent;
    cllc_pkg::mode_t   n_mode;
    cllc_pkg::sel_t    n_sel;
    logic [5:0]        n_valve;
    logic [3:0]        n_green;
    cllc_pkg::cmd_t    cmd;
    cllc_pkg::sel_t    cmd_to;
    logic              stop_both;
    cllc_pkg::fault_t  flt;
    cllc_pkg::cmd_t    cmd_lo, cmd_hi;

    // next state
    always_comb begin
        ev  = (req.event_code > 4'(cllc_pkg::EV_LEVEL_CHANGED)) ? 4'(cllc_pkg::EV_NONE)
                                                                 : req.event_code;
        lo  = req.low_door_state;
        hi  = req.high_door_state;
        lvl = (req.water_level > cllc_pkg::LVL_HIGH) ? cllc_pkg::LVL_HIGH : req.water_level;
        lo_open = (lo >= cllc_pkg::DOOR_OPEN) && (lo <= cllc_pkg::DOOR_STOPPED);
        hi_open = (hi >= cllc_pkg::DOOR_OPEN) && (hi <= cllc_pkg::DOOR_STOPPED);
        sel_ds  = (st.sel == cllc_pkg::SEL_LOW) ? lo : hi;
        gs   = (st.sel == cllc_pkg::SEL_HIGH) ? 2'd2 : 2'd0;
        ins  = 4'b0001 << gs;
        outs = 4'b0010 << gs;

        n_mode    = st.mode;
        n_sel     = st.sel;
        n_valve   = st.valve;
        n_green   = st.green;
        cmd       = cllc_pkg::CMD_NONE;
        cmd_to    = cllc_pkg::SEL_NONE;
        stop_both = 1'b0;
        flt       = cllc_pkg::FLT_NONE;
        ent       = '0;

        if (!st.started || (ev == 4'(cllc_pkg::EV_RESUME) &&
                            st.mode == cllc_pkg::MODE_EMERGENCY)) begin
            // start-up or resume: pick the door in service
            if (!st.started) begin
                n_valve = '0;
                n_green = '0;
            end
            if (lo >= cllc_pkg::DOOR_DAMAGE || hi >= cllc_pkg::DOOR_DAMAGE) begin
                flt = cllc_pkg::FLT_DAMAGE;
            end else if (lo_open && hi_open) begin
                flt = cllc_pkg::FLT_BOTH_OPEN;
            end else if (lo_open || hi_open) begin
                ent = lo_open ? enter_door(cllc_pkg::SEL_LOW, lo, n_green)
                              : enter_door(cllc_pkg::SEL_HIGH, hi, n_green);
                n_mode  = ent.mode;
                n_sel   = ent.sel;
                n_green = ent.green;
                cmd     = ent.cmd;
                cmd_to  = ent.sel;
            end else begin
                n_sel = cllc_pkg::SEL_NONE;
                if (lvl >= cllc_pkg::LVL_HIGH) begin
                    n_mode  = cllc_pkg::MODE_LOWERING;
                    n_valve = n_valve | cllc_pkg::VALVE_LOW_LOWER;
                end else begin
                    n_mode  = cllc_pkg::MODE_RAISING;
                    n_valve = raise_water(lvl, n_valve);
                end
            end
        end else if (ev == 4'(cllc_pkg::EV_NONE) || st.mode == cllc_pkg::MODE_EMERGENCY) begin
            // idle event, or waiting for resume
        end else if (ev == 4'(cllc_pkg::EV_ALARM) ||
                     ev == 4'(cllc_pkg::EV_EMERG_BUTTON)) begin
            n_mode    = cllc_pkg::MODE_EMERGENCY;
            n_sel     = cllc_pkg::SEL_NONE;
            n_valve   = '0;
            n_green   = '0;
            stop_both = 1'b1;
        end else begin
            cmd_to = st.sel;
            case (st.mode)
                cllc_pkg::MODE_OPENING: begin
                    if (ev == 4'(cllc_pkg::EV_START)) begin
                        n_mode = cllc_pkg::MODE_CLOSING;
                        cmd    = cllc_pkg::CMD_CLOSE;
                    end else if (ev == 4'(cllc_pkg::EV_DOOR_CHANGED) &&
                                 sel_ds == cllc_pkg::DOOR_OPEN) begin
                        n_mode = cllc_pkg::MODE_OPEN;
                        cmd    = cllc_pkg::CMD_STOP;
                    end
                end
                cllc_pkg::MODE_CLOSING: begin
                    if (ev == 4'(cllc_pkg::EV_START)) begin
                        n_mode = cllc_pkg::MODE_OPENING;
                        cmd    = cllc_pkg::CMD_OPEN;
                    end else if (ev == 4'(cllc_pkg::EV_DOOR_CHANGED) &&
                                 sel_ds == cllc_pkg::DOOR_CLOSED) begin
                        cmd   = cllc_pkg::CMD_STOP;
                        n_sel = cllc_pkg::SEL_NONE;
                        if (lvl >= cllc_pkg::LVL_HIGH) begin
                            n_mode  = cllc_pkg::MODE_LOWERING;
                            n_valve = n_valve | cllc_pkg::VALVE_LOW_LOWER;
                        end else begin
                            n_mode  = cllc_pkg::MODE_RAISING;
                            n_valve = raise_water(lvl, n_valve);
                        end
                    end
                end
                cllc_pkg::MODE_OPEN: begin
                    if (ev == 4'(cllc_pkg::EV_START)) begin
                        n_mode = cllc_pkg::MODE_CLOSING;
                        cmd    = cllc_pkg::CMD_CLOSE;
                    end else if (ev == 4'(cllc_pkg::EV_REL_OUTSIDE)) begin
                        n_mode  = cllc_pkg::MODE_OUT_GREEN;
                        n_green = n_green | outs;
                    end else if (ev == 4'(cllc_pkg::EV_REL_INSIDE)) begin
                        n_mode  = cllc_pkg::MODE_IN_GREEN;
                        n_green = n_green | ins;
                    end
                end
                cllc_pkg::MODE_OUT_GREEN: begin
                    if (ev == 4'(cllc_pkg::EV_REL_OUTSIDE)) begin
                        n_mode  = cllc_pkg::MODE_OPEN;
                        n_green = n_green & ~outs;
                    end else if (ev == 4'(cllc_pkg::EV_REL_INSIDE)) begin
                        n_mode  = cllc_pkg::MODE_IN_GREEN;
                        n_green = (n_green & ~outs) | ins;
                    end
                end
                cllc_pkg::MODE_IN_GREEN: begin
                    if (ev == 4'(cllc_pkg::EV_REL_OUTSIDE)) begin
                        n_mode  = cllc_pkg::MODE_OUT_GREEN;
                        n_green = (n_green & ~ins) | outs;
                    end else if (ev == 4'(cllc_pkg::EV_REL_INSIDE)) begin
                        n_mode  = cllc_pkg::MODE_OPEN;
                        n_green = n_green & ~ins;
                    end
                end
                cllc_pkg::MODE_RAISING: begin
                    if (ev == 4'(cllc_pkg::EV_START)) begin
                        n_mode  = cllc_pkg::MODE_LOWERING;
                        n_valve = (n_valve & cllc_pkg::VALVE_LOW_ALL) |
                                  cllc_pkg::VALVE_LOW_LOWER;
                    end else if (ev == 4'(cllc_pkg::EV_LEVEL_CHANGED)) begin
                        if (lvl >= cllc_pkg::LVL_HIGH) begin
                            n_valve = n_valve & cllc_pkg::VALVE_LOW_ALL;
                            ent     = enter_door(cllc_pkg::SEL_HIGH, hi, n_green);
                            n_mode  = ent.mode;
                            n_sel   = ent.sel;
                            n_green = ent.green;
                            cmd     = ent.cmd;
                            cmd_to  = ent.sel;
                            if (ent.damaged) flt = cllc_pkg::FLT_DAMAGE;
                        end else begin
                            n_valve = raise_water(lvl, n_valve);
                        end
                    end
                end
                cllc_pkg::MODE_LOWERING: begin
                    if (ev == 4'(cllc_pkg::EV_START)) begin
                        n_valve = n_valve & cllc_pkg::VALVE_HIGH_ALL;
                        n_mode  = cllc_pkg::MODE_RAISING;
                        n_valve = raise_water(lvl, n_valve);
                    end else if (ev == 4'(cllc_pkg::EV_LEVEL_CHANGED) &&
                                 lvl == cllc_pkg::LVL_LOW) begin
                        n_valve = n_valve & cllc_pkg::VALVE_HIGH_ALL;
                        ent     = enter_door(cllc_pkg::SEL_LOW, lo, n_green);
                        n_mode  = ent.mode;
                        n_sel   = ent.sel;
                        n_green = ent.green;
                        cmd     = ent.cmd;
                        cmd_to  = ent.sel;
                        if (ent.damaged) flt = cllc_pkg::FLT_DAMAGE;
                    end
                end
                default: begin
                end
            endcase
        end

        // a fault leaves the whole state as it was
        if (flt == cllc_pkg::FLT_NONE) begin
            st_next.started = 1'b1;
            st_next.mode    = n_mode;
            st_next.sel     = n_sel;
            st_next.valve   = n_valve;
            st_next.green   = n_green;
        end else begin
            st_next = st;
        end
    end

    // outputs
    always_comb begin
        // door commands; a fault suppresses them
        cmd_lo = cllc_pkg::CMD_NONE;
        cmd_hi = cllc_pkg::CMD_NONE;
        if (flt == cllc_pkg::FLT_NONE) begin
            if (stop_both) begin
                cmd_lo = cllc_pkg::CMD_STOP;
                cmd_hi = cllc_pkg::CMD_STOP;
            end else if (cmd_to == cllc_pkg::SEL_LOW) begin
                cmd_lo = cmd;
            end else if (cmd_to == cllc_pkg::SEL_HIGH) begin
                cmd_hi = cmd;
            end
        end

        res.fault             = flt;
        res.door_in_use       = st_next.sel;
        res.mode_now          = st_next.mode;
        res.high_door_command = cmd_hi;
        res.low_door_command  = cmd_lo;
        res.lights_green      = st_next.green;
        res.valves_open       = st_next.valve;
    end

endmodule

// File: tb/tb_canal_lock_controller.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_canal_lock_controller: self-checking bench for the canal lock controller
// Event requests go in on the s_ side and results come back on the m_ side.
// A behavioral model of the lock sequencer predicts every result. A checker
// compares each result against the oldest prediction, field by field. Named
// tests cover start-up, the door and light sequence, the water level moves and
// emergency handling. Random traffic follows, with bursty idling on both sides
// and one long receiver hold-off.
// ============================================================================
module tb_canal_lock_controller;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam int unsigned LONG_HOLD      = 80;

    // out-of-range encodings the block must tolerate
    localparam logic [3:0] EV_UNKNOWN_TOP = 4'd15;
    localparam logic [2:0] DOOR_UNDEF     = 3'd7;
    localparam logic [2:0] LVL_OVER_A     = 3'd5;
    localparam logic [2:0] LVL_OVER_B     = 3'd7;

    // light pair of one door: inside in the low bit, outside above it
    localparam logic [3:0] GREEN_IN   = 4'b0001;
    localparam logic [3:0] GREEN_OUT  = 4'b0010;
    localparam logic [3:0] GREEN_PAIR = 4'b0011;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [cllc_pkg::REQ_TW-1:0]   s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [cllc_pkg::RES_TW-1:0]   m_tdata;

    canal_lock_controller u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Lock model state (committed) and per-request working copy
    // ------------------------------------------------------------------------
    logic               lk_started;
    cllc_pkg::mode_t    lk_mode;
    cllc_pkg::sel_t     lk_sel;
    logic [5:0]         lk_valves;
    logic [3:0]         lk_green;

    cllc_pkg::mode_t    nx_mode;
    cllc_pkg::sel_t     nx_sel;
    logic [5:0]         nx_valves;
    logic [3:0]         nx_green;
    cllc_pkg::cmd_t     nx_cmd_lo;
    cllc_pkg::cmd_t     nx_cmd_hi;
    cllc_pkg::fault_t   nx_fault;

    cllc_pkg::res_t pending_lock_results[$];

    // bench control and bookkeeping
    bit              idle_on;
    int unsigned     rx_hold_cycles;
    int unsigned     error_count;
    int unsigned     req_count;
    int unsigned     res_count;
    int unsigned     damage_faults;
    int unsigned     both_open_faults;
    logic [7:0]      modes_seen;
    int unsigned     stall_cycles;
    cllc_pkg::res_t  rx_got;
    cllc_pkg::res_t  rx_want;

    // ------------------------------------------------------------------------
    // Model helpers; they act on the nx_* working copy
    // ------------------------------------------------------------------------
    function automatic void issue_door_cmd(cllc_pkg::sel_t sel, cllc_pkg::cmd_t c);
        if (sel == cllc_pkg::SEL_LOW) nx_cmd_lo = c;
        else if (sel == cllc_pkg::SEL_HIGH) nx_cmd_hi = c;
    endfunction

    function automatic int green_shift(cllc_pkg::sel_t sel);
        return (sel == cllc_pkg::SEL_HIGH) ? 2 : 0;
    endfunction

    // fill valves on the high door side, more as the level rises
    function automatic void open_fill_valves(logic [2:0] lvl);
        if (lvl <= cllc_pkg::LVL_BELOW_MID) nx_valves |= cllc_pkg::VALVE_HIGH_1;
        else if (lvl == cllc_pkg::LVL_ABOVE_MID) nx_valves |= cllc_pkg::VALVE_HIGH_2;
        else if (lvl == cllc_pkg::LVL_ABOVE_UP) nx_valves |= cllc_pkg::VALVE_HIGH_ALL;
    endfunction

    function automatic void enter_chamber_sealed(logic [2:0] lvl);
        nx_sel = cllc_pkg::SEL_NONE;
        if (lvl >= cllc_pkg::LVL_HIGH) begin
            nx_mode = cllc_pkg::MODE_LOWERING;
            nx_valves |= cllc_pkg::VALVE_LOW_LOWER;
        end else begin
            nx_mode = cllc_pkg::MODE_RAISING;
            open_fill_valves(lvl);
        end
    endfunction

    function automatic void enter_door_service(cllc_pkg::sel_t sel, logic [2:0] st);
        nx_sel = sel;
        nx_green &= ~(GREEN_PAIR << green_shift(sel));
        if (st >= cllc_pkg::DOOR_DAMAGE) begin
            nx_fault = cllc_pkg::FLT_DAMAGE;
            return;
        end
        if (st == cllc_pkg::DOOR_OPEN) begin
            nx_mode = cllc_pkg::MODE_OPEN;
        end else if (st == cllc_pkg::DOOR_CLOSING) begin
            nx_mode = cllc_pkg::MODE_CLOSING;
            issue_door_cmd(sel, cllc_pkg::CMD_CLOSE);
        end else begin
            nx_mode = cllc_pkg::MODE_OPENING;
            issue_door_cmd(sel, cllc_pkg::CMD_OPEN);
        end
    endfunction

    // start-up and resume: pick the open door, or seal the chamber
    function automatic void enter_normal_ops(logic [2:0] lo, logic [2:0] hi,
                                             logic [2:0] lvl);
        logic lo_open;
        logic hi_open;
        if (lo >= cllc_pkg::DOOR_DAMAGE || hi >= cllc_pkg::DOOR_DAMAGE) begin
            nx_fault = cllc_pkg::FLT_DAMAGE;
            return;
        end
        lo_open = (lo >= cllc_pkg::DOOR_OPEN) && (lo <= cllc_pkg::DOOR_STOPPED);
        hi_open = (hi >= cllc_pkg::DOOR_OPEN) && (hi <= cllc_pkg::DOOR_STOPPED);
        if (lo_open && hi_open) begin
            nx_fault = cllc_pkg::FLT_BOTH_OPEN;
            return;
        end
        if (lo_open) enter_door_service(cllc_pkg::SEL_LOW, lo);
        else if (hi_open) enter_door_service(cllc_pkg::SEL_HIGH, hi);
        else enter_chamber_sealed(lvl);
    endfunction

    // One lock step: advance the model state and return the expected result
    function automatic cllc_pkg::res_t predict_lock_step(cllc_pkg::req_t r);
        logic [3:0]      ev;
        logic [2:0]      lo;
        logic [2:0]      hi;
        logic [2:0]      lvl;
        logic [2:0]      sel_st;
        logic [3:0]      ins;
        logic [3:0]      outs;
        cllc_pkg::res_t  res;
        ev  = r.event_code;
        lo  = r.low_door_state;
        hi  = r.high_door_state;
        lvl = r.water_level;
        if (lvl > cllc_pkg::LVL_HIGH) lvl = cllc_pkg::LVL_HIGH;
        if (ev > cllc_pkg::EV_LEVEL_CHANGED) ev = cllc_pkg::EV_NONE;

        nx_mode   = lk_mode;
        nx_sel    = lk_sel;
        nx_valves = lk_valves;
        nx_green  = lk_green;
        nx_cmd_lo = cllc_pkg::CMD_NONE;
        nx_cmd_hi = cllc_pkg::CMD_NONE;
        nx_fault  = cllc_pkg::FLT_NONE;
        // with no door selected the high door state is what gets consulted
        sel_st    = (lk_sel == cllc_pkg::SEL_LOW) ? lo : hi;
        ins       = GREEN_IN << green_shift(lk_sel);
        outs      = GREEN_OUT << green_shift(lk_sel);

        if (!lk_started) begin
            nx_valves = '0;
            nx_green  = '0;
            enter_normal_ops(lo, hi, lvl);
        end else if (ev == cllc_pkg::EV_NONE) begin
            // idle request, nothing moves
        end else if (lk_mode == cllc_pkg::MODE_EMERGENCY) begin
            if (ev == cllc_pkg::EV_RESUME) enter_normal_ops(lo, hi, lvl);
        end else if (ev == cllc_pkg::EV_ALARM || ev == cllc_pkg::EV_EMERG_BUTTON) begin
            nx_mode   = cllc_pkg::MODE_EMERGENCY;
            nx_sel    = cllc_pkg::SEL_NONE;
            nx_valves = '0;
            nx_green  = '0;
            nx_cmd_lo = cllc_pkg::CMD_STOP;
            nx_cmd_hi = cllc_pkg::CMD_STOP;
        end else begin
            case (lk_mode)
                cllc_pkg::MODE_OPENING: begin
                    if (ev == cllc_pkg::EV_START) begin
                        nx_mode = cllc_pkg::MODE_CLOSING;
                        issue_door_cmd(lk_sel, cllc_pkg::CMD_CLOSE);
                    end else if (ev == cllc_pkg::EV_DOOR_CHANGED &&
                                 sel_st == cllc_pkg::DOOR_OPEN) begin
                        nx_mode = cllc_pkg::MODE_OPEN;
                        issue_door_cmd(lk_sel, cllc_pkg::CMD_STOP);
                    end
                end
                cllc_pkg::MODE_CLOSING: begin
                    if (ev == cllc_pkg::EV_START) begin
                        nx_mode = cllc_pkg::MODE_OPENING;
                        issue_door_cmd(lk_sel, cllc_pkg::CMD_OPEN);
                    end else if (ev == cllc_pkg::EV_DOOR_CHANGED &&
                                 sel_st == cllc_pkg::DOOR_CLOSED) begin
                        // locked is not enough to end closing
                        issue_door_cmd(lk_sel, cllc_pkg::CMD_STOP);
                        enter_chamber_sealed(lvl);
                    end
                end
                cllc_pkg::MODE_OPEN: begin
                    if (ev == cllc_pkg::EV_START) begin
                        nx_mode = cllc_pkg::MODE_CLOSING;
                        issue_door_cmd(lk_sel, cllc_pkg::CMD_CLOSE);
                    end else if (ev == cllc_pkg::EV_REL_OUTSIDE) begin
                        nx_mode = cllc_pkg::MODE_OUT_GREEN;
                        nx_green |= outs;
                    end else if (ev == cllc_pkg::EV_REL_INSIDE) begin
                        nx_mode = cllc_pkg::MODE_IN_GREEN;
                        nx_green |= ins;
                    end
                end
                cllc_pkg::MODE_OUT_GREEN: begin
                    if (ev == cllc_pkg::EV_REL_OUTSIDE) begin
                        nx_mode = cllc_pkg::MODE_OPEN;
                        nx_green &= ~outs;
                    end else if (ev == cllc_pkg::EV_REL_INSIDE) begin
                        nx_mode = cllc_pkg::MODE_IN_GREEN;
                        nx_green = (nx_green & ~outs) | ins;
                    end
                end
                cllc_pkg::MODE_IN_GREEN: begin
                    if (ev == cllc_pkg::EV_REL_OUTSIDE) begin
                        nx_mode = cllc_pkg::MODE_OUT_GREEN;
                        nx_green = (nx_green & ~ins) | outs;
                    end else if (ev == cllc_pkg::EV_REL_INSIDE) begin
                        nx_mode = cllc_pkg::MODE_OPEN;
                        nx_green &= ~ins;
                    end
                end
                cllc_pkg::MODE_RAISING: begin
                    if (ev == cllc_pkg::EV_START) begin
                        nx_valves = (nx_valves & cllc_pkg::VALVE_LOW_ALL) |
                                    cllc_pkg::VALVE_LOW_LOWER;
                        nx_mode = cllc_pkg::MODE_LOWERING;
                    end else if (ev == cllc_pkg::EV_LEVEL_CHANGED) begin
                        if (lvl >= cllc_pkg::LVL_HIGH) begin
                            nx_valves &= cllc_pkg::VALVE_LOW_ALL;
                            enter_door_service(cllc_pkg::SEL_HIGH, hi);
                        end else begin
                            open_fill_valves(lvl);
                        end
                    end
                end
                default: begin
                    // lowering
                    if (ev == cllc_pkg::EV_START) begin
                        nx_valves &= cllc_pkg::VALVE_HIGH_ALL;
                        nx_mode = cllc_pkg::MODE_RAISING;
                        open_fill_valves(lvl);
                    end else if (ev == cllc_pkg::EV_LEVEL_CHANGED &&
                                 lvl == cllc_pkg::LVL_LOW) begin
                        nx_valves &= cllc_pkg::VALVE_HIGH_ALL;
                        enter_door_service(cllc_pkg::SEL_LOW, lo);
                    end
                end
            endcase
        end

        // a fault keeps the whole state and drops the door commands
        if (nx_fault != cllc_pkg::FLT_NONE) begin
            nx_cmd_lo = cllc_pkg::CMD_NONE;
            nx_cmd_hi = cllc_pkg::CMD_NONE;
            if (nx_fault == cllc_pkg::FLT_DAMAGE) damage_faults++;
            else both_open_faults++;
        end else begin
            lk_started = 1'b1;
            lk_mode    = nx_mode;
            lk_sel     = nx_sel;
            lk_valves  = nx_valves;
            lk_green   = nx_green;
        end
        modes_seen[lk_mode] = 1'b1;

        res.valves_open       = lk_valves;
        res.lights_green      = lk_green;
        res.low_door_command  = nx_cmd_lo;
        res.high_door_command = nx_cmd_hi;
        res.mode_now          = lk_mode;
        res.door_in_use       = lk_sel;
        res.fault             = nx_fault;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request generation and the shared send task
    // ------------------------------------------------------------------------
    function automatic cllc_pkg::req_t mk_req(logic [3:0] ev, logic [2:0] lo,
                                              logic [2:0] hi, logic [2:0] lvl);
        cllc_pkg::req_t r;
        r.event_code      = ev;
        r.low_door_state  = lo;
        r.high_door_state = hi;
        r.water_level     = lvl;
        return r;
    endfunction

    // Mostly sensible traffic: one door shut, the other often open or closed,
    // so the sequencer gets past emergency and into the deeper modes.
    function automatic cllc_pkg::req_t random_request();
        cllc_pkg::req_t r;
        int unsigned    pick;
        logic [2:0]     shut_st;
        logic [2:0]     free_st;
        pick = $urandom_range(0, 99);
        if (pick < 3) r.event_code = cllc_pkg::EV_ALARM;
        else if (pick < 5) r.event_code = cllc_pkg::EV_EMERG_BUTTON;
        else if (pick < 12) r.event_code = cllc_pkg::EV_RESUME;
        else if (pick < 15) r.event_code = cllc_pkg::EV_NONE;
        else if (pick < 19)
            r.event_code = 4'($urandom_range(cllc_pkg::EV_LEVEL_CHANGED + 1, EV_UNKNOWN_TOP));
        else
            r.event_code = 4'($urandom_range(cllc_pkg::EV_START, cllc_pkg::EV_LEVEL_CHANGED));

        if ($urandom_range(0, 9) < 8) begin
            shut_st = $urandom_range(0, 1) ? cllc_pkg::DOOR_CLOSED : cllc_pkg::DOOR_LOCKED;
            if ($urandom_range(0, 3) == 0)
                free_st = 3'($urandom_range(cllc_pkg::DOOR_LOCKED, cllc_pkg::DOOR_STOPPED));
            else
                free_st = $urandom_range(0, 1) ? cllc_pkg::DOOR_OPEN : cllc_pkg::DOOR_CLOSED;
            if ($urandom_range(0, 1)) begin
                r.low_door_state  = shut_st;
                r.high_door_state = free_st;
            end else begin
                r.low_door_state  = free_st;
                r.high_door_state = shut_st;
            end
        end else begin
            r.low_door_state  = 3'($urandom_range(cllc_pkg::DOOR_LOCKED, DOOR_UNDEF));
            r.high_door_state = 3'($urandom_range(cllc_pkg::DOOR_LOCKED, DOOR_UNDEF));
        end

        if ($urandom_range(0, 99) < 85)
            r.water_level = 3'($urandom_range(cllc_pkg::LVL_LOW, cllc_pkg::LVL_HIGH));
        else
            r.water_level = 3'($urandom_range(cllc_pkg::LVL_LOW, LVL_OVER_B));
        return r;
    endfunction

    // Called and returns at a falling edge; valid stays high between
    // back-to-back requests and drops only for an idle burst.
    task automatic send_request(input cllc_pkg::req_t r);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {{(cllc_pkg::REQ_TW-cllc_pkg::REQ_W){1'b0}}, r};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_lock_results.push_back(predict_lock_step(r));
        req_count++;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random bursts of back-pressure, plus a long hold on request
    // ------------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge aclk);
                rx_hold_cycles = 0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned want,
                                        int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rx_got = cllc_pkg::res_t'(m_tdata[cllc_pkg::RES_W-1:0]);
            res_count++;
            if (pending_lock_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected nothing, got %h",
                         $time, rx_got);
                error_count++;
            end else begin
                rx_want = pending_lock_results.pop_front();
                check_field("valves_open", rx_want.valves_open, rx_got.valves_open);
                check_field("lights_green", rx_want.lights_green, rx_got.lights_green);
                check_field("low_door_command", rx_want.low_door_command,
                            rx_got.low_door_command);
                check_field("high_door_command", rx_want.high_door_command,
                            rx_got.high_door_command);
                check_field("mode_now", rx_want.mode_now, rx_got.mode_now);
                check_field("door_in_use", rx_want.door_in_use, rx_got.door_in_use);
                check_field("fault", rx_want.fault, rx_got.fault);
            end
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, pending_lock_results.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // start-up retried after each fault; the event of the start-up request
    // is ignored, and an out-of-range level must not matter here
    task automatic test_startup();
        send_request(mk_req(cllc_pkg::EV_START, cllc_pkg::DOOR_OPEN, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_NONE, DOOR_UNDEF, cllc_pkg::DOOR_CLOSED,
                            cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_ALARM, cllc_pkg::DOOR_OPENING,
                            cllc_pkg::DOOR_LOCKED, LVL_OVER_B));
    endtask

    // low door: open, every light transition, closing and the locked case
    task automatic test_door_sequence();
        send_request(mk_req(EV_UNKNOWN_TOP, cllc_pkg::DOOR_OPENING, cllc_pkg::DOOR_LOCKED,
                            cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_DOOR_CHANGED, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_REL_OUTSIDE, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_REL_INSIDE, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_REL_OUTSIDE, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_REL_OUTSIDE, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_REL_INSIDE, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_REL_INSIDE, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_START, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_DOOR_CHANGED, cllc_pkg::DOOR_LOCKED,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_START, cllc_pkg::DOOR_CLOSING,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_START, cllc_pkg::DOOR_OPENING,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_DOOR_CHANGED, cllc_pkg::DOOR_CLOSED,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_ABOVE_MID));
    endtask

    // raising through the levels, hand-over to the high door, lowering,
    // and raising restarted at a level that is already high
    task automatic test_water_levels();
        send_request(mk_req(cllc_pkg::EV_LEVEL_CHANGED, cllc_pkg::DOOR_CLOSED,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_ABOVE_UP));
        send_request(mk_req(cllc_pkg::EV_LEVEL_CHANGED, cllc_pkg::DOOR_CLOSED,
                            cllc_pkg::DOOR_CLOSING, LVL_OVER_A));
        send_request(mk_req(cllc_pkg::EV_DOOR_CHANGED, cllc_pkg::DOOR_CLOSED,
                            cllc_pkg::DOOR_CLOSED, cllc_pkg::LVL_HIGH));
        send_request(mk_req(cllc_pkg::EV_START, cllc_pkg::DOOR_CLOSED,
                            cllc_pkg::DOOR_CLOSED, cllc_pkg::LVL_HIGH));
        send_request(mk_req(cllc_pkg::EV_START, cllc_pkg::DOOR_CLOSED,
                            cllc_pkg::DOOR_CLOSED, cllc_pkg::LVL_HIGH));
        send_request(mk_req(cllc_pkg::EV_LEVEL_CHANGED, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::DOOR_CLOSED, cllc_pkg::LVL_LOW));
    endtask

    // emergency entry, events ignored while stopped, failed and good resumes
    task automatic test_emergency();
        send_request(mk_req(cllc_pkg::EV_EMERG_BUTTON, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::DOOR_CLOSED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_START, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::DOOR_CLOSED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_RESUME, cllc_pkg::DOOR_OPEN,
                            cllc_pkg::DOOR_DAMAGE, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_RESUME, cllc_pkg::DOOR_CLOSED,
                            cllc_pkg::DOOR_STOPPED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_ALARM, cllc_pkg::DOOR_CLOSED,
                            cllc_pkg::DOOR_STOPPED, cllc_pkg::LVL_LOW));
        send_request(mk_req(cllc_pkg::EV_RESUME, cllc_pkg::DOOR_LOCKED,
                            cllc_pkg::DOOR_LOCKED, cllc_pkg::LVL_BELOW_MID));
    endtask

    task automatic test_random_traffic(input int unsigned count, input bit bursts);
        idle_on = bursts;
        repeat (count) send_request(random_request());
    endtask

    // receiver holds off long enough that the block fills and stalls s_tready
    task automatic test_backpressure();
        idle_on = 1'b0;
        rx_hold_cycles = LONG_HOLD;
        repeat (30) send_request(random_request());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        idle_on        = 1'b0;
        rx_hold_cycles = 0;
        error_count    = 0;
        req_count      = 0;
        res_count      = 0;
        damage_faults  = 0;
        both_open_faults = 0;
        modes_seen     = '0;
        stall_cycles   = 0;
        lk_started     = 1'b0;
        lk_mode        = cllc_pkg::MODE_EMERGENCY;
        lk_sel         = cllc_pkg::SEL_NONE;
        lk_valves      = '0;
        lk_green       = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        idle_on = 1'b1;
        test_startup();
        test_door_sequence();
        test_water_levels();
        test_emergency();
        test_random_traffic(380, 1'b1);
        test_backpressure();
        test_random_traffic(40, 1'b0);
        s_tvalid <= 1'b0;

        while (pending_lock_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests, %0d results checked, %0d errors",
                 req_count, res_count, error_count);
        $display("faults: %0d motor damage, %0d both open; mode set %b",
                 damage_faults, both_open_faults, modes_seen);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
